@@ design/sbr_pkg.sv @@
// ----------------------------------------------------------------------------
// Subpixel box resolve package
// Shared constants, register codes, channel payloads and control structs.
// ----------------------------------------------------------------------------
`default_nettype none

package sbr_pkg;

    localparam int MAX_LEVEL_DEF = 4;
    localparam int MAX_WIDTH_DEF = 1024;

    localparam int LEVEL_RESET = 1;
    localparam int WIDTH_RESET = 1024;

    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 11;
    localparam int LEVEL_CFG_W = 3;
    localparam int WIDTH_CFG_W = 11;

    localparam int COLOR_W     = 8;
    localparam int DEPTH_W     = 16;
    localparam int PIXEL_X_W   = 10;
    localparam int CHANNEL_MAX = 255;

    localparam logic [DEPTH_W-1:0] DEPTH_EMPTY = 16'hFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEVEL = 1'b0,
        REG_WIDTH = 1'b1
    } cfg_reg_t;

    typedef logic [PIXEL_X_W-1:0] pixel_x_t;

    typedef struct packed {
        logic [COLOR_W-1:0] in_red;
        logic [COLOR_W-1:0] in_green;
        logic [COLOR_W-1:0] in_blue;
        logic [DEPTH_W-1:0] in_depth;
        logic               frame_start;
    } in_item_t;

    typedef struct packed {
        logic [COLOR_W-1:0] out_red;
        logic [COLOR_W-1:0] out_green;
        logic [COLOR_W-1:0] out_blue;
        logic [COLOR_W-1:0] out_alpha;
        logic [DEPTH_W-1:0] out_depth;
        pixel_x_t           pixel_x;
        logic               row_last;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic rd;
        logic update;
        logic div_init;
        logic div_step;
        logic out_load;
        logic pos_init;
        logic pos_step;
        logic pos_done;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_last;
        logic out_free;
        logic level_wr;
    } ctrl_status_t;

endpackage

`default_nettype wire

@@ design/subpixel_box_resolve_unit.sv @@
// ----------------------------------------------------------------------------
// Subpixel box resolve unit
// Box-filter resolve of a supersampled image streamed in raster order.
// ----------------------------------------------------------------------------
//
//   Port group   Direction   Handshake           Payload
//   s_*          in          s_valid / s_ready   sbr_pkg::in_item_t
//   m_*          out         m_valid / m_ready   sbr_pkg::out_item_t
//   cfg_*        in          cfg_wr_en           cfg_index, cfg_wr_data
//
// A sample that completes no pixel passes through accept, accumulator read and
// write-back. A sample that completes a pixel passes through those, 8 steps of the
// shift-subtract divider for the averages and alpha, and the load of the output
// register, where the pixel waits for m_ready while the next samples are taken.
// A write of the level register holds s_ready low for the position rebuild: init,
// column-by-level divide, done. Reset leaves the accumulator RAM as it is.
//
`default_nettype none

module subpixel_box_resolve_unit #(
    parameter int MAX_LEVEL = sbr_pkg::MAX_LEVEL_DEF,
    parameter int MAX_WIDTH = sbr_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [sbr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [sbr_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire sbr_pkg::in_item_t               s_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output sbr_pkg::out_item_t                   m_data
);

    sbr_pkg::ctrl_cmd_t    cmd;
    sbr_pkg::ctrl_status_t status;

    sbr_ctrl #(
        .MAX_LEVEL (MAX_LEVEL),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .status  (status)
    );

    sbr_datapath #(
        .MAX_LEVEL (MAX_LEVEL),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

`default_nettype wire

@@ design/sbr_ram.sv @@
// ----------------------------------------------------------------------------
// Subpixel box resolve RAM
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ design/sbr_ctrl.sv @@
// ----------------------------------------------------------------------------
// Subpixel box resolve controller
// Sequences sample accumulation, the output divide and the position rebuild.
// ----------------------------------------------------------------------------
`default_nettype none

module sbr_ctrl #(
    parameter int MAX_LEVEL = sbr_pkg::MAX_LEVEL_DEF,
    parameter int MAX_WIDTH = sbr_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    output sbr_pkg::ctrl_cmd_t         cmd,
    input  wire sbr_pkg::ctrl_status_t status
);

    localparam int CW     = $clog2(MAX_WIDTH * MAX_LEVEL);
    localparam int CNT_W  = $clog2((CW > 8) ? CW : 8);
    localparam int QSTEPS = sbr_pkg::COLOR_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_UPDATE,
        S_DIV,
        S_OUT,
        S_POS_INIT,
        S_POS_STEP,
        S_POS_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               stale_reg, stale_next;
    logic               ready_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        stale_next = stale_reg || status.level_wr;
        cmd        = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && ready_reg) begin
                    cmd.load   = 1'b1;
                    state_next = S_READ;
                end else if (stale_reg) begin
                    state_next = S_POS_INIT;
                end
            end
            S_READ: begin
                cmd.rd     = 1'b1;
                state_next = S_UPDATE;
            end
            S_UPDATE: begin
                cmd.update = 1'b1;
                if (status.is_last) begin
                    cmd.div_init = 1'b1;
                    cnt_next     = CNT_W'(QSTEPS - 1);
                    state_next   = S_DIV;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0) begin
                    state_next = S_OUT;
                end else begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            S_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_POS_INIT: begin
                cmd.pos_init = 1'b1;
                stale_next   = status.level_wr;
                cnt_next     = CNT_W'(CW - 1);
                state_next   = S_POS_STEP;
            end
            S_POS_STEP: begin
                cmd.pos_step = 1'b1;
                if (cnt_reg == '0) begin
                    state_next = S_POS_DONE;
                end else begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            S_POS_DONE: begin
                cmd.pos_done = 1'b1;
                state_next   = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            stale_reg <= 1'b0;
            ready_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            stale_reg <= stale_next;
            ready_reg <= (state_next == S_IDLE) && !stale_next;
        end
    end

    assign s_ready = ready_reg;

endmodule

`default_nettype wire

@@ design/sbr_datapath.sv @@
// ----------------------------------------------------------------------------
// Subpixel box resolve datapath
// Configuration, subpixel position, column accumulators, dividers and output.
// ----------------------------------------------------------------------------
`default_nettype none

module sbr_datapath #(
    parameter int MAX_LEVEL = sbr_pkg::MAX_LEVEL_DEF,
    parameter int MAX_WIDTH = sbr_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [sbr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [sbr_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  wire sbr_pkg::in_item_t                 s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output sbr_pkg::out_item_t                     m_data,
    input  wire sbr_pkg::ctrl_cmd_t                cmd,
    output sbr_pkg::ctrl_status_t                  status
);

    localparam int LW     = $clog2(MAX_LEVEL + 1);
    localparam int SXW    = (MAX_LEVEL > 1) ? $clog2(MAX_LEVEL) : 1;
    localparam int PXW    = $clog2(MAX_WIDTH + 1);
    localparam int AW     = $clog2(MAX_WIDTH);
    localparam int CW     = $clog2(MAX_WIDTH * MAX_LEVEL);
    localparam int CNTW   = $clog2(MAX_LEVEL * MAX_LEVEL + 1);
    localparam int SW     = $clog2(sbr_pkg::CHANNEL_MAX * MAX_LEVEL * MAX_LEVEL + 1);
    localparam int CLW    = sbr_pkg::COLOR_W;
    localparam int DW     = sbr_pkg::DEPTH_W;
    localparam int QW     = CNTW + CLW;
    localparam int PXO_W  = sbr_pkg::PIXEL_X_W;
    localparam int NLANE  = 4;
    localparam int L_RED  = 0;
    localparam int L_GRN  = 1;
    localparam int L_BLU  = 2;
    localparam int L_ALP  = 3;
    localparam int WD_RST = (sbr_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                               : sbr_pkg::WIDTH_RESET;

    typedef struct packed {
        logic [SW-1:0]   red;
        logic [SW-1:0]   green;
        logic [SW-1:0]   blue;
        logic [DW-1:0]   depth;
        logic [CNTW-1:0] hits;
    } acc_t;

    localparam int WW = $bits(acc_t);

    // Configuration.
    logic [LW-1:0]   lv_reg, lv_next;
    logic [PXW-1:0]  wd_reg, wd_next;
    logic [CNTW-1:0] sq_reg, sq_next;
    logic [sbr_pkg::LEVEL_CFG_W-1:0] lvl_in;
    logic [sbr_pkg::WIDTH_CFG_W-1:0] wdt_in;
    logic [LW-1:0]   lv_clamp;
    logic [PXW-1:0]  wd_clamp;

    // Position.
    logic [CW-1:0]   col_reg, col_next;
    logic [PXW-1:0]  px_reg, px_next;
    logic [SXW-1:0]  sx_reg, sx_next;
    logic [SXW-1:0]  ph_reg, ph_next;
    logic [CW-1:0]   dq_reg, dq_next;
    logic [LW-1:0]   prem_reg, prem_next;
    logic [LW:0]     pos_t;
    logic [LW:0]     pos_sub;
    logic            pos_ge;
    logic            sx_end;
    logic            ph_end;
    logic            px_end;

    // Sample and accumulators.
    logic [CLW-1:0]  red_reg, green_reg, blue_reg;
    logic [DW-1:0]   dep_reg;
    logic [WW-1:0]   ram_rdata;
    acc_t            acc_base;
    acc_t            acc_new;
    logic            first;

    // Output divider.
    logic [QW-1:0]   rem_reg [NLANE];
    logic [QW-1:0]   rem_next [NLANE];
    logic [CLW-1:0]  q_reg [NLANE];
    logic [CLW-1:0]  q_next [NLANE];
    logic [QW-1:0]   num [NLANE];
    logic [QW-1:0]   dsh_reg, dsh_next;
    logic [DW-1:0]   rdep_reg, rdep_next;
    logic [PXW-1:0]  rpx_reg, rpx_next;
    logic            rlast_reg, rlast_next;

    // Output register.
    logic                m_valid_reg, m_valid_next;
    sbr_pkg::out_item_t  m_data_reg, m_data_next;

    always_comb begin
        lvl_in = cfg_wr_data[sbr_pkg::LEVEL_CFG_W-1:0];
        wdt_in = cfg_wr_data[sbr_pkg::WIDTH_CFG_W-1:0];
        if (lvl_in == '0) begin
            lv_clamp = LW'(1);
        end else if (lvl_in > MAX_LEVEL) begin
            lv_clamp = LW'(MAX_LEVEL);
        end else begin
            lv_clamp = LW'(lvl_in);
        end
        if (wdt_in == '0) begin
            wd_clamp = PXW'(1);
        end else if (wdt_in > MAX_WIDTH) begin
            wd_clamp = PXW'(MAX_WIDTH);
        end else begin
            wd_clamp = PXW'(wdt_in);
        end

        lv_next = lv_reg;
        wd_next = wd_reg;
        sq_next = sq_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                sbr_pkg::REG_LEVEL: begin
                    lv_next = lv_clamp;
                    sq_next = CNTW'(CNTW'(lv_clamp) * CNTW'(lv_clamp));
                end
                sbr_pkg::REG_WIDTH: begin
                    wd_next = wd_clamp;
                end
                default: begin
                    lv_next = lv_reg;
                end
            endcase
        end
    end

    assign status.level_wr = cfg_wr_en && (cfg_index == sbr_pkg::REG_LEVEL);

    assign sx_end = (LW'(sx_reg) == lv_reg - LW'(1));
    assign ph_end = (LW'(ph_reg) == lv_reg - LW'(1));
    assign px_end = (px_reg == wd_reg - PXW'(1));

    assign pos_t   = {prem_reg, dq_reg[CW-1]};
    assign pos_ge  = (pos_t >= {1'b0, lv_reg});
    assign pos_sub = pos_t - {1'b0, lv_reg};

    always_comb begin
        col_next  = col_reg;
        px_next   = px_reg;
        sx_next   = sx_reg;
        ph_next   = ph_reg;
        dq_next   = dq_reg;
        prem_next = prem_reg;

        if (cmd.load) begin
            if (s_data.frame_start || (px_reg >= wd_reg)) begin
                col_next = '0;
                px_next  = '0;
                sx_next  = '0;
            end
            if (s_data.frame_start || (LW'(ph_reg) >= lv_reg)) begin
                ph_next = '0;
            end
        end

        if (cmd.update) begin
            if (sx_end) begin
                sx_next = '0;
                if (px_end) begin
                    px_next  = '0;
                    col_next = '0;
                    ph_next  = ph_end ? '0 : ph_reg + SXW'(1);
                end else begin
                    px_next  = px_reg + PXW'(1);
                    col_next = col_reg + CW'(1);
                end
            end else begin
                sx_next  = sx_reg + SXW'(1);
                col_next = col_reg + CW'(1);
            end
        end

        if (cmd.pos_init) begin
            dq_next   = col_reg;
            prem_next = '0;
        end
        if (cmd.pos_step) begin
            prem_next = pos_ge ? pos_sub[LW-1:0] : pos_t[LW-1:0];
            dq_next   = {dq_reg[CW-2:0], pos_ge};
        end
        if (cmd.pos_done) begin
            px_next = (dq_reg >= MAX_WIDTH) ? PXW'(MAX_WIDTH) : PXW'(dq_reg);
            sx_next = SXW'(prem_reg);
        end
    end

    assign status.is_last = sx_end && ph_end;

    sbr_ram #(
        .WIDTH (WW),
        .DEPTH (MAX_WIDTH)
    ) u_acc_ram (
        .aclk    (aclk),
        .wr_en   (cmd.update),
        .wr_addr (px_reg[AW-1:0]),
        .wr_data (WW'(acc_new)),
        .rd_en   (cmd.rd),
        .rd_addr (px_reg[AW-1:0]),
        .rd_data (ram_rdata)
    );

    always_comb begin
        first    = (sx_reg == '0) && (ph_reg == '0);
        acc_base = first ? '0 : acc_t'(ram_rdata);
        acc_new  = acc_base;
        if (dep_reg != '0) begin
            acc_new.red   = acc_base.red + SW'(red_reg);
            acc_new.green = acc_base.green + SW'(green_reg);
            acc_new.blue  = acc_base.blue + SW'(blue_reg);
            acc_new.hits  = acc_base.hits + CNTW'(1);
            if (dep_reg > acc_base.depth) begin
                acc_new.depth = dep_reg;
            end
        end
    end

    always_comb begin
        num[L_RED] = QW'(acc_new.red);
        num[L_GRN] = QW'(acc_new.green);
        num[L_BLU] = QW'(acc_new.blue);
        num[L_ALP] = (QW'(acc_new.hits) << CLW) - QW'(acc_new.hits);

        dsh_next   = dsh_reg;
        rdep_next  = rdep_reg;
        rpx_next   = rpx_reg;
        rlast_next = rlast_reg;
        for (int i = 0; i < NLANE; i++) begin
            rem_next[i] = rem_reg[i];
            q_next[i]   = q_reg[i];
        end

        if (cmd.div_init) begin
            for (int i = 0; i < NLANE; i++) begin
                rem_next[i] = num[i];
                q_next[i]   = '0;
            end
            dsh_next   = QW'(sq_reg) << (CLW - 1);
            rdep_next  = (acc_new.hits == '0) ? sbr_pkg::DEPTH_EMPTY : acc_new.depth;
            rpx_next   = px_reg;
            rlast_next = px_end;
        end else if (cmd.div_step) begin
            for (int i = 0; i < NLANE; i++) begin
                if (rem_reg[i] >= dsh_reg) begin
                    rem_next[i] = rem_reg[i] - dsh_reg;
                    q_next[i]   = {q_reg[i][CLW-2:0], 1'b1};
                end else begin
                    q_next[i]   = {q_reg[i][CLW-2:0], 1'b0};
                end
            end
            dsh_next = dsh_reg >> 1;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.out_load) begin
            m_valid_next          = 1'b1;
            m_data_next.out_red   = q_reg[L_RED];
            m_data_next.out_green = q_reg[L_GRN];
            m_data_next.out_blue  = q_reg[L_BLU];
            m_data_next.out_alpha = q_reg[L_ALP];
            m_data_next.out_depth = rdep_reg;
            m_data_next.pixel_x   = PXO_W'(rpx_reg);
            m_data_next.row_last  = rlast_reg;
        end
    end

    assign status.out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lv_reg      <= LW'(sbr_pkg::LEVEL_RESET);
            wd_reg      <= PXW'(WD_RST);
            sq_reg      <= CNTW'(sbr_pkg::LEVEL_RESET * sbr_pkg::LEVEL_RESET);
            col_reg     <= '0;
            px_reg      <= '0;
            sx_reg      <= '0;
            ph_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            lv_reg      <= lv_next;
            wd_reg      <= wd_next;
            sq_reg      <= sq_next;
            col_reg     <= col_next;
            px_reg      <= px_next;
            sx_reg      <= sx_next;
            ph_reg      <= ph_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            red_reg   <= s_data.in_red;
            green_reg <= s_data.in_green;
            blue_reg  <= s_data.in_blue;
            dep_reg   <= s_data.in_depth;
        end
        dq_reg     <= dq_next;
        prem_reg   <= prem_next;
        for (int i = 0; i < NLANE; i++) begin
            rem_reg[i] <= rem_next[i];
            q_reg[i]   <= q_next[i];
        end
        dsh_reg    <= dsh_next;
        rdep_reg   <= rdep_next;
        rpx_reg    <= rpx_next;
        rlast_reg  <= rlast_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire
